### sv/icl_pkg.sv
// Shared types, codes and sizes for the indexed circular list.
`default_nettype none
package icl_pkg;

   // store geometry
   localparam int RING_DEPTH  = 64;
   localparam int DATA_WIDTH  = 32;
   localparam int ADDR_WIDTH  = $clog2(RING_DEPTH);
   localparam int COUNT_WIDTH = $clog2(RING_DEPTH + 1);

   // operation codes of a request
   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_READ   = 2'd2;
   localparam logic [1:0] CMD_SET    = 2'd3;

   // status codes of a response
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]        cmd;
      logic signed [7:0] position;
      logic [31:0]       value;
   } icl_req_type;

   typedef struct packed {
      logic [31:0] data_out;
      logic [6:0]  count_out;
      logic [1:0]  status;
   } icl_rsp_type;

   // work to be done on the store once a request is checked
   typedef enum logic [2:0] {
      OP_NONE,
      OP_INSERT,
      OP_REMOVE,
      OP_READ,
      OP_WRITE
   } icl_op_type;

   typedef struct packed {
      logic [1:0]            status;
      icl_op_type            op;
      logic [ADDR_WIDTH-1:0] index;
      logic                  front;
      logic                  ascend;
      logic [ADDR_WIDTH-1:0] moves;
      logic [ADDR_WIDTH-1:0] first_src;
   } icl_plan_type;

   typedef struct packed {
      logic                  en;
      logic [ADDR_WIDTH-1:0] addr;
      logic [DATA_WIDTH-1:0] data;
   } icl_wr_type;

endpackage
`default_nettype wire

### sv/icl_ring.sv
// Ring store: one write port, one read port with registered read data.
`default_nettype none
module icl_ring (
   input  wire                            clock,
   input  icl_pkg::icl_wr_type            wr,
   input  wire  [icl_pkg::ADDR_WIDTH-1:0] rd_addr,
   output logic [icl_pkg::DATA_WIDTH-1:0] rd_data
);
   import icl_pkg::*;

   logic [DATA_WIDTH-1:0] mem_ff [RING_DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   // write when asked, read every cycle
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### sv/icl_check.sv
// Request check: index range, fullness, and the shift plan for the store.
`default_nettype none
module icl_check (
   input  icl_pkg::icl_req_type             req,
   input  wire  [icl_pkg::COUNT_WIDTH-1:0]  count,
   output icl_pkg::icl_plan_type            plan
);
   import icl_pkg::*;

   logic signed [8:0]      pos_s;
   logic signed [8:0]      cnt_s;
   logic                   neg;
   logic                   minus_one;
   logic                   gt_n;
   logic                   ge_n;
   logic                   full;
   logic [COUNT_WIDTH-1:0] k;
   logic [COUNT_WIDTH-1:0] half;
   logic [COUNT_WIDTH-1:0] mv;
   logic [COUNT_WIDTH-1:0] src;
   logic                   front;

   always_comb begin
      pos_s     = {req.position[7], req.position};
      cnt_s     = signed'({2'b00, count});
      neg       = req.position[7];
      minus_one = (req.position == -8'sd1);
      gt_n      = pos_s > cnt_s;
      ge_n      = pos_s >= cnt_s;
      full      = (count == COUNT_WIDTH'(RING_DEPTH));
      half      = count >> 1;

      plan.status = ST_OK;
      plan.op     = OP_NONE;
      k           = req.position[COUNT_WIDTH-1:0];

      // classify the request
      unique case (req.cmd)
         CMD_INSERT: begin
            if (neg || gt_n) begin
               plan.status = ST_RANGE;
            end else if (full) begin
               plan.status = ST_FULL;
            end else begin
               plan.op = OP_INSERT;
            end
         end
         CMD_REMOVE: begin
            if (neg || ge_n) begin
               plan.status = ST_RANGE;
            end else begin
               plan.op = OP_REMOVE;
            end
         end
         CMD_READ: begin
            if (neg || ge_n) begin
               plan.status = ST_RANGE;
            end else begin
               plan.op = OP_READ;
            end
         end
         CMD_SET: begin
            if ((neg && !minus_one) || gt_n) begin
               plan.status = ST_RANGE;
            end else if (minus_one || !ge_n == 1'b0) begin
               // front insert or append
               if (full) begin
                  plan.status = ST_FULL;
               end else begin
                  plan.op = OP_INSERT;
                  k       = minus_one ? '0 : count;
               end
            end else begin
               plan.op = OP_WRITE;
            end
         end
         default: begin
            plan.status = ST_RANGE;
         end
      endcase

      // pick the shorter side to shift
      if (plan.op == OP_REMOVE) begin
         front = k < half;
         mv    = front ? k : count - k - COUNT_WIDTH'(1);
         src   = front ? k - COUNT_WIDTH'(1) : k + COUNT_WIDTH'(1);
      end else begin
         front = k <= half;
         mv    = front ? k : count - k;
         src   = front ? COUNT_WIDTH'(1) : count - COUNT_WIDTH'(1);
      end

      plan.index     = k[ADDR_WIDTH-1:0];
      plan.front     = front;
      plan.ascend    = (plan.op == OP_REMOVE) ? !front : front;
      plan.moves     = mv[ADDR_WIDTH-1:0];
      plan.first_src = src[ADDR_WIDTH-1:0];
   end

endmodule
`default_nettype wire

### sv/indexed_circular_list.sv
// Indexed circular list: sequencer over the ring store and its address adder.
// Steps: a rejected request is answered after DECIDE, a read or overwrite after DECIDE and GRAB,
// an insert after DECIDE, SHIFT and FINAL, and a remove after DECIDE, GRAB, SHIFT and FINAL; in SHIFT,
// m (0 to 31) entries are moved one slot along the shorter side.
// Moves go one per cycle through the single ring port pair.
// busy drops as the response strobes, so the next request can be accepted in that cycle.
// Reset clears head and count; ring contents are not cleared and need no clearing pass.
`default_nettype none
module indexed_circular_list (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   output logic                  busy,
   input  icl_pkg::icl_req_type  req_item,
   output logic                  rsp_valid,
   output icl_pkg::icl_rsp_type  rsp_item
);
   import icl_pkg::*;

   typedef enum logic [2:0] {
      IDLE_ST,
      DECIDE_ST,
      GRAB_ST,
      SHIFT_ST,
      FINAL_ST
   } state_type;

   state_type              state_ff;
   logic                   busy_ff;
   logic                   rsp_valid_ff;
   icl_rsp_type            rsp_ff;
   icl_req_type            req_ff;
   icl_op_type             op_ff;
   logic [ADDR_WIDTH-1:0]  k_ff;
   logic                   front_ff;
   logic                   ascend_ff;
   logic [ADDR_WIDTH-1:0]  left_ff;
   logic [ADDR_WIDTH-1:0]  pos_ff;
   logic                   pend_ff;
   logic [ADDR_WIDTH-1:0]  wa_ff;
   logic [ADDR_WIDTH-1:0]  head_ff;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [DATA_WIDTH-1:0]  data_ff;

   icl_plan_type           plan;
   icl_wr_type             wr;
   logic [ADDR_WIDTH-1:0]  idx;
   logic [ADDR_WIDTH-1:0]  ring_addr;
   logic [DATA_WIDTH-1:0]  rd_data;

   icl_check u_check (
      .req   (req_ff),
      .count (count_ff),
      .plan  (plan)
   );

   icl_ring u_ring (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (ring_addr),
      .rd_data (rd_data)
   );

   // shared address adder: physical slot of a logical index
   always_comb begin
      unique case (state_ff)
         SHIFT_ST:  idx = pos_ff;
         DECIDE_ST: idx = plan.index;
         default:   idx = k_ff;
      endcase
      ring_addr = head_ff + idx;
   end

   // store writes: a shifted entry, an overwrite or the inserted word
   always_comb begin
      wr.en   = 1'b0;
      wr.addr = ring_addr;
      wr.data = req_ff.value;
      if (state_ff == SHIFT_ST && pend_ff) begin
         wr.en   = 1'b1;
         wr.addr = wa_ff;
         wr.data = rd_data;
      end else if ((state_ff == GRAB_ST && op_ff == OP_WRITE) ||
                   (state_ff == FINAL_ST && op_ff == OP_INSERT)) begin
         wr.en = 1'b1;
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE_ST;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         head_ff      <= '0;
         count_ff     <= '0;
      end else begin
         unique case (state_ff)
            IDLE_ST: begin
               rsp_valid_ff <= 1'b0;
               if (start) begin
                  req_ff   <= req_item;
                  busy_ff  <= 1'b1;
                  state_ff <= DECIDE_ST;
               end
            end
            DECIDE_ST: begin
               op_ff        <= plan.op;
               k_ff         <= plan.index;
               front_ff     <= plan.front;
               ascend_ff    <= plan.ascend;
               left_ff      <= plan.moves;
               pos_ff       <= plan.first_src;
               pend_ff      <= 1'b0;
               rsp_valid_ff <= (plan.status != ST_OK);
               if (plan.status != ST_OK) begin
                  rsp_ff   <= '{data_out: '0, count_out: count_ff, status: plan.status};
                  busy_ff  <= 1'b0;
                  state_ff <= IDLE_ST;
               end else if (plan.op == OP_INSERT) begin
                  if (plan.front) begin
                     head_ff <= head_ff - ADDR_WIDTH'(1);
                  end
                  state_ff <= SHIFT_ST;
               end else begin
                  state_ff <= GRAB_ST;
               end
            end
            GRAB_ST: begin
               data_ff      <= rd_data;
               rsp_valid_ff <= (op_ff != OP_REMOVE);
               if (op_ff == OP_REMOVE) begin
                  state_ff <= SHIFT_ST;
               end else begin
                  rsp_ff   <= '{data_out: rd_data, count_out: count_ff, status: ST_OK};
                  busy_ff  <= 1'b0;
                  state_ff <= IDLE_ST;
               end
            end
            SHIFT_ST: begin
               rsp_valid_ff <= 1'b0;
               // read one entry per cycle, write it one slot along in the following cycle
               if (left_ff != '0) begin
                  wa_ff   <= ascend_ff ? ring_addr - ADDR_WIDTH'(1)
                                       : ring_addr + ADDR_WIDTH'(1);
                  pos_ff  <= ascend_ff ? pos_ff + ADDR_WIDTH'(1) : pos_ff - ADDR_WIDTH'(1);
                  left_ff <= left_ff - ADDR_WIDTH'(1);
                  pend_ff <= 1'b1;
               end else begin
                  pend_ff <= 1'b0;
                  if (!pend_ff) begin
                     state_ff <= FINAL_ST;
                  end
               end
            end
            FINAL_ST: begin
               if (op_ff == OP_INSERT) begin
                  count_ff <= count_ff + COUNT_WIDTH'(1);
                  rsp_ff   <= '{data_out: '0, count_out: count_ff + COUNT_WIDTH'(1),
                                status: ST_OK};
               end else begin
                  if (front_ff) begin
                     head_ff <= head_ff + ADDR_WIDTH'(1);
                  end
                  count_ff <= count_ff - COUNT_WIDTH'(1);
                  rsp_ff   <= '{data_out: data_ff, count_out: count_ff - COUNT_WIDTH'(1),
                                status: ST_OK};
               end
               rsp_valid_ff <= 1'b1;
               busy_ff      <= 1'b0;
               state_ff     <= IDLE_ST;
            end
            default: begin
               rsp_valid_ff <= 1'b0;
               state_ff     <= IDLE_ST;
               busy_ff      <= 1'b0;
            end
         endcase
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule
`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the indexed circular list.
`timescale 1ns / 1ps
module testbench;
   import icl_pkg::*;

   localparam int WATCHDOG_LIMIT    = 1000;
   localparam int SETTLE_CYCLES     = 50;
   localparam int MAX_PRINTED       = 40;
   localparam int RANDOM_PHASES     = 12;
   localparam int ITEMS_PER_PHASE   = 150;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   icl_req_type req_item;
   logic        rsp_valid;
   icl_rsp_type rsp_item;

   // list contents in logical order, front first
   logic [DATA_WIDTH-1:0] list_words[$];
   icl_rsp_type           expected_responses[$];
   int                    error_count;
   int                    stall_cycles;
   bit                    no_gaps;

   indexed_circular_list dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   always #1 clock = ~clock;

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= MAX_PRINTED)
         $display("%0t: mismatch: %s", $realtime, what);
   endtask

   // work out the response of one request and apply it to the list
   function automatic icl_rsp_type predict_list_op(input icl_req_type req);
      icl_rsp_type rsp;
      int          pos;
      int          n;
      rsp = '0;
      pos = $signed(req.position);
      n   = list_words.size();
      case (req.cmd)
         CMD_INSERT: begin
            if (pos < 0 || pos > n)
               rsp.status = ST_RANGE;
            else if (n >= RING_DEPTH)
               rsp.status = ST_FULL;
            else
               list_words.insert(pos, req.value);
         end
         CMD_REMOVE: begin
            if (pos < 0 || pos >= n) begin
               rsp.status = ST_RANGE;
            end else begin
               rsp.data_out = list_words[pos];
               list_words.delete(pos);
            end
         end
         CMD_READ: begin
            if (pos < 0 || pos >= n)
               rsp.status = ST_RANGE;
            else
               rsp.data_out = list_words[pos];
         end
         CMD_SET: begin
            if (pos < -1 || pos > n) begin
               rsp.status = ST_RANGE;
            end else if (pos == -1 || pos == n) begin
               // front insert or append
               if (n >= RING_DEPTH)
                  rsp.status = ST_FULL;
               else if (pos == -1)
                  list_words.push_front(req.value);
               else
                  list_words.push_back(req.value);
            end else begin
               rsp.data_out    = list_words[pos];
               list_words[pos] = req.value;
            end
         end
      endcase
      rsp.count_out = COUNT_WIDTH'(list_words.size());
      return rsp;
   endfunction

   // drive one request from a falling edge, hold it until accepted, then draw the gap
   task automatic send_request(input icl_req_type req);
      int gap;
      start    <= 1'b1;
      req_item <= req;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      expected_responses.push_back(predict_list_op(req));
      @(negedge clock);
      gap = no_gaps ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic send_op(input logic [1:0] cmd, input int pos, input logic [31:0] value);
      icl_req_type req;
      req.cmd      = cmd;
      req.position = 8'(pos);
      req.value    = value;
      send_request(req);
   endtask

   // hold requests off until every outstanding response has come
   task automatic drain_responses();
      start <= 1'b0;
      while (expected_responses.size() != 0)
         @(negedge clock);
      @(negedge clock);
   endtask

   function automatic logic [31:0] random_word();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0)
         return '0;
      else if (pick == 1)
         return '1;
      return $urandom;
   endfunction

   // well-formed request most of the time, with edge and wild indexes mixed in
   function automatic icl_req_type random_request(input int grow_pct, input int shrink_pct);
      icl_req_type req;
      int          n;
      int          pick;
      n         = list_words.size();
      pick      = $urandom_range(0, 99);
      req.value = random_word();
      if (pick < grow_pct) begin
         case ($urandom_range(0, 2))
            0: begin
               req.cmd      = CMD_INSERT;
               req.position = 8'($urandom_range(0, n));
            end
            1: begin
               req.cmd      = CMD_SET;
               req.position = -8'sd1;
            end
            default: begin
               req.cmd      = CMD_SET;
               req.position = 8'(n);
            end
         endcase
      end else if (pick < grow_pct + shrink_pct) begin
         req.cmd      = CMD_REMOVE;
         req.position = 8'((n == 0) ? 0 : $urandom_range(0, n - 1));
      end else begin
         req.cmd      = $urandom_range(0, 1) ? CMD_READ : CMD_SET;
         req.position = 8'((n == 0) ? 0 : $urandom_range(0, n - 1));
      end
      // disturb the index now and then
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         req.position = 8'($urandom_range(0, 255));
      end else if (pick < 14) begin
         case ($urandom_range(0, 3))
            0: req.position = -8'sd1;
            1: req.position = -8'sd2;
            2: req.position = 8'(n);
            default: req.position = 8'(n + 1);
         endcase
      end
      if ($urandom_range(0, 19) == 0)
         req.cmd = 2'($urandom_range(0, 3));
      return req;
   endfunction

   // empty list, every operation, both edges, out-of-range indexes
   task automatic test_edges();
      send_op(CMD_READ,   0,    32'h0000_0001);
      send_op(CMD_REMOVE, 0,    32'h0000_0002);
      send_op(CMD_INSERT, 1,    32'h0000_0003);
      send_op(CMD_INSERT, -1,   32'h0000_0004);
      send_op(CMD_SET,    -2,   32'h0000_0005);
      send_op(CMD_SET,    0,    32'h0000_0000);
      send_op(CMD_SET,    -1,   32'hFFFF_FFFF);
      send_op(CMD_INSERT, 2,    32'h8000_0001);
      send_op(CMD_INSERT, 1,    32'h1234_5678);
      for (int i = 0; i < 4; i++)
         send_op(CMD_READ, i, 32'hDEAD_BEEF);
      send_op(CMD_SET,    1,    32'hA5A5_5A5A);
      send_op(CMD_READ,   4,    32'h0000_0000);
      send_op(CMD_REMOVE, 3,    32'h0000_0000);
      send_op(CMD_REMOVE, 0,    32'h0000_0000);
      send_op(CMD_SET,    127,  32'h7FFF_FFFF);
      send_op(CMD_INSERT, -128, 32'h5555_5555);
      send_op(CMD_REMOVE, 1,    32'h0000_0000);
      send_op(CMD_READ,   0,    32'h0000_0000);
      send_op(CMD_REMOVE, 0,    32'h0000_0000);
      send_op(CMD_REMOVE, 0,    32'h0000_0000);
      drain_responses();
   endtask

   // fill to capacity back to back, probe the full store, then empty it
   task automatic test_full_store();
      no_gaps = 1'b1;
      while (list_words.size() < RING_DEPTH)
         send_op(CMD_INSERT, $urandom_range(0, list_words.size()), random_word());
      send_op(CMD_INSERT, 32,               32'h0BAD_0001);
      send_op(CMD_SET,    -1,               32'h0BAD_0002);
      send_op(CMD_SET,    RING_DEPTH,       32'h0BAD_0003);
      send_op(CMD_INSERT, RING_DEPTH + 1,   32'h0BAD_0004);
      send_op(CMD_SET,    RING_DEPTH + 1,   32'h0BAD_0005);
      send_op(CMD_READ,   RING_DEPTH - 1,   32'h0000_0000);
      send_op(CMD_SET,    RING_DEPTH - 1,   32'hFFFF_FFFF);
      send_op(CMD_READ,   RING_DEPTH,       32'h0000_0000);
      no_gaps = 1'b0;
      while (list_words.size() > 0) begin
         if ($urandom_range(0, 3) == 0)
            send_op(CMD_READ, $urandom_range(0, list_words.size() - 1), 32'h0);
         send_op(CMD_REMOVE, $urandom_range(0, list_words.size() - 1), 32'h0);
      end
      drain_responses();
   endtask

   // alternate growing and shrinking phases so the count sweeps both ends
   task automatic test_random_mix();
      int grow;
      int shrink;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         grow    = phase[0] ? 20 : 50;
         shrink  = phase[0] ? 50 : 20;
         no_gaps = (phase % 3 == 2);
         for (int i = 0; i < ITEMS_PER_PHASE; i++)
            send_request(random_request(grow, shrink));
         if (phase % 4 == 3)
            drain_responses();
      end
      no_gaps = 1'b0;
   endtask

   // compare each response with the oldest prediction
   always @(posedge clock) begin
      icl_rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_responses.size() == 0) begin
            report_mismatch("response with none outstanding");
         end else begin
            want = expected_responses.pop_front();
            if (rsp_item.data_out !== want.data_out)
               report_mismatch($sformatf("data_out %h, want %h",
                                         rsp_item.data_out, want.data_out));
            if (rsp_item.count_out !== want.count_out)
               report_mismatch($sformatf("count_out %0d, want %0d",
                                         rsp_item.count_out, want.count_out));
            if (rsp_item.status !== want.status)
               report_mismatch($sformatf("status %0d, want %0d",
                                         rsp_item.status, want.status));
         end
      end
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      clock        = 1'b0;
      reset        = 1'b1;
      start        = 1'b0;
      req_item     = '0;
      error_count  = 0;
      stall_cycles = 0;
      no_gaps      = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_edges();
      test_full_store();
      test_random_mix();

      drain_responses();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (error_count == 0 && expected_responses.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

### files.f
sv/icl_pkg.sv
sv/icl_ring.sv
sv/icl_check.sv
sv/indexed_circular_list.sv
tb/testbench.sv
